/* sv/utf16_text_sanitizer_macros.svh */
// Assertion macros shared by the UTF-16 text sanitizer modules.
`ifndef UTF16_TEXT_SANITIZER_MACROS_SVH
`define UTF16_TEXT_SANITIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Assertion failed in same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define UTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Assertion failed in next cycle.");

`endif

/* sv/uts_pkg.sv */
// Shared types, constants and helper functions of the UTF-16 text sanitizer.
package uts_pkg;

    localparam logic [15:0] U_TAB       = 16'h0009;
    localparam logic [15:0] U_LF        = 16'h000A;
    localparam logic [15:0] U_CR        = 16'h000D;
    localparam logic [15:0] U_BACKSLASH = 16'h005C;
    localparam logic [15:0] U_LETTER_N  = 16'h006E;
    localparam logic [15:0] U_LETTER_T  = 16'h0074;
    localparam logic [15:0] U_LETTER_U  = 16'h0075;
    localparam logic [15:0] U_LINE_SEP  = 16'h2028;
    localparam logic [15:0] U_PARA_SEP  = 16'h2029;
    localparam logic [15:0] U_HIGH_MIN  = 16'hD800;
    localparam logic [15:0] U_HIGH_MAX  = 16'hDBFF;
    localparam logic [15:0] U_LOW_MIN   = 16'hDC00;
    localparam logic [15:0] U_LOW_MAX   = 16'hDFFF;
    localparam logic [15:0] U_C0_END    = 16'h0020;
    localparam logic [15:0] U_C1_MIN    = 16'h007F;
    localparam logic [15:0] U_C1_MAX    = 16'h009F;

    localparam int          QUEUE_DEPTH = 2;
    localparam logic [3:0]  ESC_LEN     = 4'd6;
    localparam logic [3:0]  STEP_MAX    = 4'd11;

    typedef enum logic [2:0] {
        K_NONE,
        K_ONE,
        K_TWO,
        K_NL_ESC,
        K_TAB,
        K_ESC
    } t_kind;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_text;
    } t_in;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        run_last;
    } t_out;

    typedef struct packed {
        logic        pre_esc;
        logic [15:0] pre_unit;
        t_kind       kind;
        logic [15:0] unit;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    function automatic logic [15:0] hex_digit(input logic [3:0] nib);
        logic [15:0] d;
        case (nib)
            4'h0: d = 16'h0030;
            4'h1: d = 16'h0031;
            4'h2: d = 16'h0032;
            4'h3: d = 16'h0033;
            4'h4: d = 16'h0034;
            4'h5: d = 16'h0035;
            4'h6: d = 16'h0036;
            4'h7: d = 16'h0037;
            4'h8: d = 16'h0038;
            4'h9: d = 16'h0039;
            4'hA: d = 16'h0041;
            4'hB: d = 16'h0042;
            4'hC: d = 16'h0043;
            4'hD: d = 16'h0044;
            4'hE: d = 16'h0045;
            default: d = 16'h0046;
        endcase
        return d;
    endfunction

    function automatic logic [15:0] esc_unit(input logic [15:0] u, input logic [2:0] idx);
        logic [15:0] d;
        case (idx)
            3'd0: d = U_BACKSLASH;
            3'd1: d = U_LETTER_U;
            3'd2: d = hex_digit(u[15:12]);
            3'd3: d = hex_digit(u[11:8]);
            3'd4: d = hex_digit(u[7:4]);
            default: d = hex_digit(u[3:0]);
        endcase
        return d;
    endfunction

endpackage

/* sv/uts_front.sv */
// Front end: accepts code units, tracks CR and surrogate state, and queues output jobs.
`include "utf16_text_sanitizer_macros.svh"

module uts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_allow_lb,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  uts_pkg::t_in   i_in_data,
    input  logic           i_full,
    output uts_pkg::t_push o_push
);

    logic        r_cr;
    logic        n_cr;
    logic        r_held_v;
    logic        n_held_v;
    logic [15:0] r_held_u;
    logic [15:0] n_held_u;
    logic        accept;
    uts_pkg::t_job job;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic [15:0] u;
        logic        is_hi;
        logic        is_lo;
        logic        is_ctl;
        logic        nl;
        u      = i_in_data.code_unit;
        is_hi  = (u >= uts_pkg::U_HIGH_MIN) && (u <= uts_pkg::U_HIGH_MAX);
        is_lo  = (u >= uts_pkg::U_LOW_MIN) && (u <= uts_pkg::U_LOW_MAX);
        is_ctl = (u < uts_pkg::U_C0_END) || ((u >= uts_pkg::U_C1_MIN) && (u <= uts_pkg::U_C1_MAX));
        nl     = 1'b0;
        job.pre_esc  = 1'b0;
        job.pre_unit = r_held_u;
        job.kind     = uts_pkg::K_NONE;
        job.unit     = u;
        n_cr     = 1'b0;
        n_held_v = 1'b0;
        n_held_u = r_held_u;
        if (r_held_v && is_lo) begin
            job.kind = uts_pkg::K_TWO;
        end else begin
            job.pre_esc = r_held_v;
            if (u == uts_pkg::U_CR) begin
                nl   = 1'b1;
                n_cr = 1'b1;
            end else if (u == uts_pkg::U_LF) begin
                nl = !r_cr;
            end else if (u == uts_pkg::U_TAB) begin
                job.kind = uts_pkg::K_TAB;
            end else if (u == uts_pkg::U_LINE_SEP || u == uts_pkg::U_PARA_SEP) begin
                job.kind = uts_pkg::K_ESC;
            end else if (is_hi) begin
                if (i_in_data.end_of_text) begin
                    job.kind = uts_pkg::K_ESC;
                end else begin
                    n_held_v = 1'b1;
                    n_held_u = u;
                end
            end else if (is_lo || is_ctl) begin
                job.kind = uts_pkg::K_ESC;
            end else begin
                job.kind = uts_pkg::K_ONE;
            end
            if (nl) begin
                if (i_allow_lb) begin
                    job.kind = uts_pkg::K_ONE;
                    job.unit = uts_pkg::U_LF;
                end else begin
                    job.kind = uts_pkg::K_NL_ESC;
                end
            end
        end
        if (i_in_data.end_of_text) begin
            n_cr = 1'b0;
        end
    end

    assign o_push.valid = accept && (job.pre_esc || (job.kind != uts_pkg::K_NONE));
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr     <= 1'b0;
            r_held_v <= 1'b0;
        end else if (accept) begin
            r_cr     <= n_cr;
            r_held_v <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held_u <= n_held_u;
        end
    end

    `UTS_ASSERT_NEXT(a_eot_clears_state, i_clk, i_rst_n,
        accept && i_in_data.end_of_text, !r_held_v && !r_cr)

endmodule

/* sv/uts_queue.sv */
// Two-entry job queue between the front end and the output sequencer.
`include "utf16_text_sanitizer_macros.svh"

module uts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  uts_pkg::t_push i_push,
    output logic           o_full,
    output uts_pkg::t_job  o_head,
    output logic           o_head_valid,
    input  logic           i_pop
);

    localparam int PW = $clog2(uts_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(uts_pkg::QUEUE_DEPTH + 1);

    uts_pkg::t_job r_entry [uts_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full       = (r_count == CW'(uts_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entry[r_rptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= (r_wptr == PW'(uts_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(uts_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wptr] <= i_push.job;
        end
    end

    `UTS_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, i_push.valid, !o_full)
    `UTS_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(uts_pkg::QUEUE_DEPTH))

endmodule

/* sv/uts_back.sv */
// Output sequencer: expands queued jobs into output-register units, one per cycle unless stalled.
`include "utf16_text_sanitizer_macros.svh"

module uts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uts_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uts_pkg::t_out o_out_data
);

    logic [3:0]    r_step;
    logic          r_out_valid;
    uts_pkg::t_out r_out;
    logic          load;
    logic          job_last;
    logic [3:0]    total;
    logic [3:0]    main_idx;
    logic [15:0]   unit;

    assign load = i_job_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        logic [3:0] main_len;
        case (i_job.kind)
            uts_pkg::K_ONE:    main_len = 4'd1;
            uts_pkg::K_TWO:    main_len = 4'd2;
            uts_pkg::K_NL_ESC: main_len = 4'd2;
            uts_pkg::K_TAB:    main_len = 4'd2;
            uts_pkg::K_ESC:    main_len = uts_pkg::ESC_LEN;
            default:           main_len = 4'd0;
        endcase
        total    = (i_job.pre_esc ? uts_pkg::ESC_LEN : 4'd0) + main_len;
        main_idx = i_job.pre_esc ? (r_step - uts_pkg::ESC_LEN) : r_step;
    end

    assign job_last = (r_step == total - 4'd1);

    always_comb begin
        if (i_job.pre_esc && (r_step < uts_pkg::ESC_LEN)) begin
            unit = uts_pkg::esc_unit(i_job.pre_unit, r_step[2:0]);
        end else begin
            case (i_job.kind)
                uts_pkg::K_TWO:
                    unit = (main_idx == 4'd0) ? i_job.pre_unit : i_job.unit;
                uts_pkg::K_NL_ESC:
                    unit = (main_idx == 4'd0) ? uts_pkg::U_BACKSLASH : uts_pkg::U_LETTER_N;
                uts_pkg::K_TAB:
                    unit = (main_idx == 4'd0) ? uts_pkg::U_BACKSLASH : uts_pkg::U_LETTER_T;
                uts_pkg::K_ESC:
                    unit = uts_pkg::esc_unit(i_job.unit, main_idx[2:0]);
                default:
                    unit = i_job.unit;
            endcase
        end
    end

    assign o_pop = load && job_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= job_last ? 4'd0 : r_step + 4'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_unit <= unit;
            r_out.run_last <= job_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UTS_ASSERT_NEXT(a_step_restarts, i_clk, i_rst_n, load && job_last, r_step == 4'd0)
    `UTS_ASSERT_SAME(a_step_bounded, i_clk, i_rst_n, 1'b1, r_step <= uts_pkg::STEP_MAX)

endmodule

/* sv/utf16_text_sanitizer.sv */
// Top level of the UTF-16 text sanitizer: configuration register and front, queue, back.
//
// Input transactions carry one UTF-16 code unit and an end-of-text flag on a
// valid/ready channel. Output transactions carry one sanitized code unit and
// run_last, which marks the final unit produced by an input transaction.
// A plain unit gives one output, a newline one or two, a tab two, an escape
// six, and a held high surrogate followed by a non-low unit up to twelve.
// Units that are held or swallowed produce no output transaction. Accepted
// units' jobs pass through the queue to the output register. The front end
// accepts one transaction per cycle while the two-entry job queue has room;
// the output sequencer emits one unit per cycle while the receiver is ready,
// so the sustained rate is set by the single output port. When the receiver
// stalls, the output register holds its unit, the queue fills and input ready
// drops. The allow_line_breaks register sits at byte address 0 of the APB
// port; the user must write it only while the block is idle, which the block
// does not enforce. Reset clears the register, the CR and surrogate state, the
// queue and the output register; no clearing pass is needed.
module utf16_text_sanitizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  uts_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uts_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic           r_allow_lb;
    logic           q_full;
    logic           q_head_valid;
    logic           pop;
    uts_pkg::t_push push;
    uts_pkg::t_job  head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_allow_lb} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_lb <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_allow_lb <= pwdata[0];
        end
    end

    uts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_allow_lb (r_allow_lb),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (push)
    );

    uts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (q_full),
        .o_head       (head),
        .o_head_valid (q_head_valid),
        .i_pop        (pop)
    );

    uts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head),
        .i_job_valid (q_head_valid),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* verif/utf16_text_sanitizer_checker.sv */
// Checker for the UTF-16 text sanitizer: predicts each output unit and compares it.
`timescale 1ns / 100ps

module utf16_text_sanitizer_checker #(
    parameter logic [2:0] ALLOW_LINE_BREAKS_ADDR = 3'd0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  uts_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  uts_pkg::t_out i_out_data,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    input  logic          i_pready,
    output int            o_fail_count,
    output int            o_units_pending
);
    import uts_pkg::*;

    logic          line_breaks_on;
    logic          cr_seen;
    logic          high_held;
    logic [15:0]   high_unit;
    logic [15:0]   fresh_units[$];
    t_out          expected_units[$];
    t_out          oldest_unit;
    int            fail_count;

    function automatic logic [15:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 16'h0030 + nib : 16'h0037 + nib;
    endfunction

    function automatic void add_escape(input logic [15:0] u);
        fresh_units.push_back(U_BACKSLASH);
        fresh_units.push_back(U_LETTER_U);
        for (int s = 12; s >= 0; s -= 4) begin
            fresh_units.push_back(hex_char(u[s +: 4]));
        end
    endfunction

    function automatic void add_newline();
        if (line_breaks_on) begin
            fresh_units.push_back(U_LF);
        end else begin
            fresh_units.push_back(U_BACKSLASH);
            fresh_units.push_back(U_LETTER_N);
        end
    endfunction

    function automatic void sanitize(input t_in item);
        logic [15:0] u;
        logic        prev_cr;
        logic        is_hi;
        logic        is_lo;
        u       = item.code_unit;
        prev_cr = cr_seen;
        is_hi   = (u >= U_HIGH_MIN) && (u <= U_HIGH_MAX);
        is_lo   = (u >= U_LOW_MIN) && (u <= U_LOW_MAX);
        cr_seen = 1'b0;
        fresh_units.delete();
        if (high_held && is_lo) begin
            high_held = 1'b0;
            fresh_units.push_back(high_unit);
            fresh_units.push_back(u);
        end else begin
            if (high_held) begin
                high_held = 1'b0;
                add_escape(high_unit);
            end
            if (u == U_CR) begin
                add_newline();
                cr_seen = 1'b1;
            end else if (u == U_LF) begin
                if (!prev_cr) begin
                    add_newline();
                end
            end else if (u == U_TAB) begin
                fresh_units.push_back(U_BACKSLASH);
                fresh_units.push_back(U_LETTER_T);
            end else if (is_hi) begin
                if (item.end_of_text) begin
                    add_escape(u);
                end else begin
                    high_held = 1'b1;
                    high_unit = u;
                end
            end else if (u == U_LINE_SEP || u == U_PARA_SEP || is_lo || u < U_C0_END
                         || (u >= U_C1_MIN && u <= U_C1_MAX)) begin
                add_escape(u);
            end else begin
                fresh_units.push_back(u);
            end
        end
        if (item.end_of_text) begin
            cr_seen = 1'b0;
        end
        foreach (fresh_units[k]) begin
            expected_units.push_back('{out_unit: fresh_units[k],
                                       run_last: (k == fresh_units.size() - 1)});
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_breaks_on = 1'b0;
            cr_seen        = 1'b0;
            high_held      = 1'b0;
            high_unit      = '0;
            expected_units.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == ALLOW_LINE_BREAKS_ADDR) begin
                line_breaks_on = i_pwdata[0];
            end
            if (i_in_valid && i_in_ready) begin
                sanitize(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_units.size() == 0) begin
                    $error("Unexpected output transaction: out_unit %h run_last %b",
                           i_out_data.out_unit, i_out_data.run_last);
                    fail_count++;
                end else begin
                    oldest_unit = expected_units.pop_front();
                    if (i_out_data.out_unit !== oldest_unit.out_unit) begin
                        $error("Mismatch on out_unit: expected %h, actual %h",
                               oldest_unit.out_unit, i_out_data.out_unit);
                        fail_count++;
                    end
                    if (i_out_data.run_last !== oldest_unit.run_last) begin
                        $error("Mismatch on run_last: expected %b, actual %b",
                               oldest_unit.run_last, i_out_data.run_last);
                        fail_count++;
                    end
                end
            end
        end
        o_units_pending <= expected_units.size();
        o_fail_count    <= fail_count;
    end

endmodule

/* verif/tb_utf16_text_sanitizer.sv */
// Testbench top for the UTF-16 text sanitizer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_utf16_text_sanitizer;
    import uts_pkg::*;

    localparam logic [2:0] ALLOW_LINE_BREAKS_ADDR = 3'd0;
    localparam int         LONG_HOLD              = 60;
    localparam int         QUIET_LIMIT            = 2000;
    localparam int         SETTLE_CYCLES          = 4;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in         in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          units_pending;
    int          tx_gap_pct    = 10;
    int          rx_stall_pct  = 73;
    int          hold_requests = 0;
    int          quiet_cycles  = 0;

    logic [16:0] opening_text [26] = '{
        {16'h0041, 1'b0}, {16'h0000, 1'b0}, {16'hFFFF, 1'b0}, {U_CR, 1'b0},
        {U_LF, 1'b0}, {U_LF, 1'b0}, {U_CR, 1'b0}, {U_CR, 1'b0},
        {U_TAB, 1'b0}, {U_LINE_SEP, 1'b0}, {16'h001F, 1'b0}, {U_C1_MIN, 1'b0},
        {U_C1_MAX, 1'b0}, {U_HIGH_MIN, 1'b0}, {U_LOW_MIN, 1'b0}, {16'hD83D, 1'b0},
        {U_PARA_SEP, 1'b0}, {U_HIGH_MAX, 1'b0}, {U_LOW_MAX, 1'b0}, {U_HIGH_MIN, 1'b0},
        {16'hD801, 1'b0}, {16'h0041, 1'b0}, {U_LOW_MIN, 1'b0}, {U_HIGH_MAX, 1'b1},
        {U_CR, 1'b1}, {U_LF, 1'b1}
    };

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    utf16_text_sanitizer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    utf16_text_sanitizer_checker #(
        .ALLOW_LINE_BREAKS_ADDR (ALLOW_LINE_BREAKS_ADDR)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (mismatches),
        .o_units_pending (units_pending)
    );

    task automatic send_unit(input logic [15:0] u, input logic ends_text);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{code_unit: u, end_of_text: ends_text};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (units_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] random_unit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return 16'($urandom_range(16'h007E, 16'h0020));
        if (pick < 45) return 16'($urandom_range(16'hFFFF, 16'h0000));
        if (pick < 52) return U_CR;
        if (pick < 58) return U_LF;
        if (pick < 63) return U_TAB;
        if (pick < 70) return 16'($urandom_range(U_C0_END - 1, 16'h0000));
        if (pick < 76) return 16'($urandom_range(U_C1_MAX, U_C1_MIN));
        if (pick < 80) return $urandom_range(1) ? U_LINE_SEP : U_PARA_SEP;
        if (pick < 87) return 16'($urandom_range(U_HIGH_MAX, U_HIGH_MIN));
        if (pick < 93) return 16'($urandom_range(U_LOW_MAX, U_LOW_MIN));
        return 16'($urandom_range(16'hFFFF, 16'h00A0));
    endfunction

    task automatic send_texts(input int target, input bit with_hold);
        int   sent;
        int   len;
        int   pick;
        bit   hold_done;
        logic ends_text;
        sent      = 0;
        hold_done = 1'b0;
        while (sent < target) begin
            len = $urandom_range(12, 1);
            for (int k = 0; k < len; k++) begin
                pick      = $urandom_range(99);
                ends_text = (k == len - 1);
                if (pick < 12) begin
                    send_unit(16'($urandom_range(U_HIGH_MAX, U_HIGH_MIN)), 1'b0);
                    send_unit(16'($urandom_range(U_LOW_MAX, U_LOW_MIN)), ends_text);
                    sent += 2;
                end else if (pick < 20) begin
                    send_unit(U_CR, 1'b0);
                    send_unit(U_LF, ends_text);
                    sent += 2;
                end else begin
                    send_unit(random_unit(), ends_text);
                    sent++;
                end
                if (with_hold && !hold_done && sent >= target / 2) begin
                    hold_done = 1'b1;
                    hold_requests++;
                end
            end
        end
    endtask

    initial begin
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (served != hold_requests) begin
                served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL utf16_text_sanitizer");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_text[k]) begin
            send_unit(opening_text[k][16:1], opening_text[k][0]);
        end
        settle();
        write_register(ALLOW_LINE_BREAKS_ADDR, 32'h0000_0001);
        send_texts(50, 1'b1);
        settle();

        tx_gap_pct   = 73;
        rx_stall_pct = 10;
        write_register(ALLOW_LINE_BREAKS_ADDR, 32'hFFFF_FFFE);
        send_texts(50, 1'b0);
        settle();

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_register(ALLOW_LINE_BREAKS_ADDR, 32'hFFFF_FFFF);
        send_texts(50, 1'b1);
        settle();

        if (mismatches == 0) begin
            $display("PASS utf16_text_sanitizer");
        end else begin
            $display("FAIL utf16_text_sanitizer");
        end
        $finish;
    end

endmodule

/* utf16_text_sanitizer.f */
+incdir+sv
sv/uts_pkg.sv
sv/uts_front.sv
sv/uts_queue.sv
sv/uts_back.sv
sv/utf16_text_sanitizer.sv
verif/utf16_text_sanitizer_checker.sv
verif/tb_utf16_text_sanitizer.sv
